[rtl/lookback_edge_detector_core_defines.svh]
// ----------------------------------------------------------------------------
// lookback edge detector assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LOOKBACK_EDGE_DETECTOR_CORE_DEFINES_SVH
`define LOOKBACK_EDGE_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, off while reset is low
`define LED_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define LED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset too
`define LED_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/led_pkg.sv]
// ----------------------------------------------------------------------------
// led_pkg
// shared types and constants of the lookback edge detector
// ----------------------------------------------------------------------------
`default_nettype none

package led_pkg;

    // configuration port
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int REG_INDEX_BITS = APB_ADDR_BITS - 2;

    // register indexes
    localparam logic [REG_INDEX_BITS-1:0] REG_EDGE_THRESHOLD = 1'b0;

    localparam int                      THRESHOLD_BITS  = 16;
    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd6553;

    localparam int INDEX_BITS = 32;

    typedef enum logic [1:0] {
        EDGE_NEUTRAL = 2'd0,
        EDGE_RISING  = 2'd1,
        EDGE_FALLING = 2'd2
    } t_edge_state;

    // decision for one sample
    typedef struct packed {
        logic        emit;
        logic        rising;
        t_edge_state next_state;
    } t_edge_eval;

endpackage

`default_nettype wire

[rtl/led_apb_regs.sv]
// ----------------------------------------------------------------------------
// led_apb_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none

module led_apb_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [led_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [led_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [led_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                     pready,
    output logic      [led_pkg::THRESHOLD_BITS-1:0]  o_threshold
);
    import led_pkg::*;

    logic [THRESHOLD_BITS-1:0] r_threshold;
    logic [REG_INDEX_BITS-1:0] reg_index;
    logic                      wr_en;

    assign reg_index = paddr[APB_ADDR_BITS-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (wr_en && (reg_index == REG_EDGE_THRESHOLD)) begin
            r_threshold <= pwdata[THRESHOLD_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_EDGE_THRESHOLD) begin
            prdata = {{(APB_DATA_BITS-THRESHOLD_BITS){1'b0}}, r_threshold};
        end
    end

    assign o_threshold = r_threshold;

endmodule

`default_nettype wire

[rtl/led_line.sv]
// ----------------------------------------------------------------------------
// led_line
// lookback shift line with fill count
// ----------------------------------------------------------------------------
`default_nettype none

module led_line #(
    parameter int LOOKBACK    = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_shift,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed      [SAMPLE_BITS-1:0] o_oldest,
    output logic                               o_full
);
    localparam int FILL_BITS = $clog2(LOOKBACK + 1);

    logic signed [SAMPLE_BITS-1:0] r_line [LOOKBACK];
    logic        [FILL_BITS-1:0]   r_fill;

    // tap 0 newest, last tap is the sample LOOKBACK positions back
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_line[0] <= i_sample;
            for (int i = 1; i < LOOKBACK; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    // saturating count of stored samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_shift && !o_full) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    assign o_full   = (r_fill == FILL_BITS'(LOOKBACK));
    assign o_oldest = r_line[LOOKBACK-1];

endmodule

`default_nettype wire

[rtl/led_edge_eval.sv]
// ----------------------------------------------------------------------------
// led_edge_eval
// difference, threshold compare and edge state decision
// ----------------------------------------------------------------------------
`default_nettype none

module led_edge_eval #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                i_full,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_current,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_earlier,
    input  wire logic [led_pkg::THRESHOLD_BITS-1:0]  i_threshold,
    input  wire led_pkg::t_edge_state                i_state,
    output led_pkg::t_edge_eval                      o_eval
);
    import led_pkg::*;

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int CMP_BITS  = (DIFF_BITS > THRESHOLD_BITS) ? DIFF_BITS : THRESHOLD_BITS;

    logic signed [DIFF_BITS-1:0] diff;
    logic        [DIFF_BITS-1:0] mag;
    logic        [CMP_BITS-1:0]  mag_ext;
    logic        [CMP_BITS-1:0]  thr_ext;
    logic                        over;
    t_edge_state                 dir;

    // one bit wider than the samples, never overflows
    assign diff    = {i_current[SAMPLE_BITS-1], i_current}
                   - {i_earlier[SAMPLE_BITS-1], i_earlier};
    assign mag     = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    assign mag_ext = CMP_BITS'(mag);
    assign thr_ext = CMP_BITS'(i_threshold);
    assign over    = (mag_ext > thr_ext);
    assign dir     = diff[DIFF_BITS-1] ? EDGE_FALLING : EDGE_RISING;

    always_comb begin
        o_eval.emit       = 1'b0;
        o_eval.rising     = (dir == EDGE_RISING);
        o_eval.next_state = i_state;
        if (i_full) begin
            if (over) begin
                if (i_state != dir) begin
                    o_eval.emit       = 1'b1;
                    o_eval.next_state = dir;
                end
            end else begin
                o_eval.next_state = EDGE_NEUTRAL;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/lookback_edge_detector_core.sv]
// path: an accepted sample is held in the input register, then any event it raises is loaded into the result register
// throughput: one sample per clock; the only stall comes from a held result
//   with another sample waiting in the input register
// reset: synchronous active low; clears fill count, edge state, position counter,
//   valids and sets the threshold to 6553; the lookback line is not cleared
// ----------------------------------------------------------------------------
// lookback_edge_detector_core
// threshold edge detector comparing each sample with one LOOKBACK back
// ----------------------------------------------------------------------------
`default_nettype none

module lookback_edge_detector_core #(
    parameter int LOOKBACK    = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // sample input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample,
    // edge event output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [led_pkg::INDEX_BITS-1:0]           o_sample_index,
    output logic signed [SAMPLE_BITS-1:0]            o_earlier_sample,
    output logic signed [SAMPLE_BITS-1:0]            o_current_sample,
    output logic                                     o_rising,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [led_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [led_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [led_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                     pready
);
    import led_pkg::*;

    // input register
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;

    // per-sample state
    t_edge_state                   r_state;
    logic [INDEX_BITS-1:0]         r_pos;

    // result register
    logic                          r_out_valid;
    logic [INDEX_BITS-1:0]         r_out_index;
    logic signed [SAMPLE_BITS-1:0] r_out_earlier;
    logic signed [SAMPLE_BITS-1:0] r_out_current;
    logic                          r_out_rising;

    logic                          in_accept;
    logic                          advance;
    logic                          line_full;
    logic signed [SAMPLE_BITS-1:0] line_oldest;
    logic [THRESHOLD_BITS-1:0]     threshold;
    t_edge_eval                    eval;

    // the held sample is processed whenever the result register is free
    // or is being emptied in this cycle
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    led_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    // line shifts after the compare, so its last tap is the sample
    // LOOKBACK positions before the one in the input register
    led_line #(
        .LOOKBACK    (LOOKBACK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (advance),
        .i_sample (r_in_sample),
        .o_oldest (line_oldest),
        .o_full   (line_full)
    );

    led_edge_eval #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_eval (
        .i_full      (line_full),
        .i_current   (r_in_sample),
        .i_earlier   (line_oldest),
        .i_threshold (threshold),
        .i_state     (r_state),
        .o_eval      (eval)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_sample <= i_sample;
        end
    end

    // edge state and position counter step once per processed sample;
    // the counter wraps naturally and filling is not restarted by the wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EDGE_NEUTRAL;
            r_pos   <= '0;
        end else if (advance) begin
            r_state <= eval.next_state;
            r_pos   <= r_pos + 1'b1;
        end
    end

    // result register valid: loaded on a processed sample, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= eval.emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, only loaded with an event
    always_ff @(posedge i_clk) begin
        if (advance && eval.emit) begin
            r_out_index   <= r_pos;
            r_out_earlier <= line_oldest;
            r_out_current <= r_in_sample;
            r_out_rising  <= eval.rising;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_index   = r_out_index;
    assign o_earlier_sample = r_out_earlier;
    assign o_current_sample = r_out_current;
    assign o_rising         = r_out_rising;

endmodule

`default_nettype wire

[rtl/led_checker.sv]
// ----------------------------------------------------------------------------
// led_checker
// port-level assertions for the lookback edge detector
// ----------------------------------------------------------------------------
`default_nettype none

`include "lookback_edge_detector_core_defines.svh"

module led_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_in_stall,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [led_pkg::INDEX_BITS-1:0] o_sample_index,
    input  wire logic signed [SAMPLE_BITS-1:0] o_earlier_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] o_current_sample,
    input  wire logic                          o_rising
);

    // held request keeps its payload
    `LED_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_sample_index) && $stable(o_earlier_sample) && $stable(o_current_sample) && $stable(o_rising), "result changed while stalled")

    // input backpressure only comes from a stalled output
    `LED_ASSERT_SAME(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without output stall")

    // direction agrees with the sample pair
    `LED_ASSERT_SAME(a_rise_dir, o_out_valid && o_rising, o_current_sample > o_earlier_sample, "rising event without rise")
    `LED_ASSERT_SAME(a_fall_dir, o_out_valid && !o_rising, o_current_sample < o_earlier_sample, "falling event without fall")

    // no result right after reset
    `LED_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind lookback_edge_detector_core led_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_led_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_sample_index   (o_sample_index),
    .o_earlier_sample (o_earlier_sample),
    .o_current_sample (o_current_sample),
    .o_rising         (o_rising)
);

`default_nettype wire
